[rtl/gncrs_pkg.sv]
`default_nettype none

package gncrs_pkg;

  localparam int unsigned GridSideDef = 16;

  localparam int unsigned CoordInW = 4;
  localparam int unsigned ClassW   = 3;
  localparam int unsigned HitClassW = 2;

  localparam logic [ClassW-1:0] MaxClass = 3'd3;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } state_e;

  typedef enum logic {
    PH_ROW,
    PH_COL
  } phase_e;

endpackage

`default_nettype wire

[rtl/grid_nearest_class_ring_search.sv]
`default_nettype none

// Nearest-class search over a GRID_SIDE x GRID_SIDE grid of cells.
// Input channel (in_valid_i / in_stall_o) carries writes and queries; a transfer
// happens when in_valid_i is high and in_stall_o is low. Output channel
// (out_valid_o / out_stall_i) carries one result per query, none per write.
// Cells live in a single synchronous RAM (one read or write per cycle).
// A query reads one on-grid cell per cycle in ring order: the start cell,
// then rings of distance 1, 2 and so on, with off-grid cells skipped.
// Bad-class and off-grid queries skip the search and go straight to the result.
// One item is worked on at a time; the next item is accepted as soon as the
// result has moved into the output register, where it may still sit.
// After reset a clearing pass writes every cell empty, with in_stall_o high.
// A stalled result holds in the output register; a finished query waits for
// that register to free up before the next item is taken.
module grid_nearest_class_ring_search #(
  parameter int unsigned GRID_SIDE = gncrs_pkg::GridSideDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic                               kind_i,
  input  wire logic [gncrs_pkg::CoordInW-1:0]     row_i,
  input  wire logic [gncrs_pkg::CoordInW-1:0]     col_i,
  input  wire logic [gncrs_pkg::ClassW-1:0]       item_class_i,
  input  wire logic                               present_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic                                    found_o,
  output logic                                    bad_query_o,
  output logic [gncrs_pkg::CoordInW-1:0]          hit_row_o,
  output logic [gncrs_pkg::CoordInW-1:0]          hit_col_o,
  output logic [gncrs_pkg::HitClassW-1:0]         hit_class_o
);

  localparam int unsigned CellCnt = GRID_SIDE * GRID_SIDE;
  localparam int unsigned AddrW   = $clog2(CellCnt);
  localparam int unsigned SideW   = $clog2(GRID_SIDE);
  localparam int unsigned CoordW  =
    ((SideW > gncrs_pkg::CoordInW) ? SideW : gncrs_pkg::CoordInW) + 2;
  localparam int unsigned OW = gncrs_pkg::CoordInW;
  localparam int unsigned HW = gncrs_pkg::HitClassW;

  typedef logic signed [CoordW-1:0] coord_t;

  localparam coord_t SideM1 = coord_t'(GRID_SIDE - 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(CellCnt - 1);

  typedef struct packed {
    logic   top_ok;
    logic   bot_ok;
    logic   left_ok;
    logic   right_ok;
    logic   any;
    coord_t row_lo;
    coord_t row_hi;
    coord_t col_lo;
    coord_t col_hi;
  } ring_t;

  function automatic ring_t ring_geo(input coord_t r, input coord_t c, input coord_t d);
    ring_t  g;
    coord_t t;
    coord_t b;
    coord_t l;
    coord_t rt;
    coord_t bm1;
    t   = r - d;
    b   = r + d;
    l   = c - d;
    rt  = c + d;
    bm1 = b - coord_t'(1);
    g.top_ok   = (t >= 0);
    g.bot_ok   = (b <= SideM1);
    g.left_ok  = (l >= 0);
    g.right_ok = (rt <= SideM1);
    g.any      = g.top_ok || g.bot_ok || g.left_ok || g.right_ok;
    g.row_lo   = (l < 0) ? '0 : l;
    g.row_hi   = (rt > SideM1) ? SideM1 : rt;
    // top corners are already covered by the row pass
    g.col_lo   = (t < 0) ? '0 : (t + coord_t'(1));
    g.col_hi   = (bm1 > SideM1) ? SideM1 : bm1;
    return g;
  endfunction

  function automatic logic [AddrW-1:0] cell_addr(input coord_t r, input coord_t c);
    return AddrW'(int'(r) * int'(GRID_SIDE) + int'(c));
  endfunction

  // Cell RAM: bit 2 occupied, bits 1:0 class
  logic [2:0]       mem_q [CellCnt];
  logic [2:0]       mem_rdata_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [2:0]       mem_wdata;
  logic             mem_re;
  logic [AddrW-1:0] mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  gncrs_pkg::state_e st_q, st_d;
  gncrs_pkg::phase_e ph_q, ph_d, nph;
  logic [AddrW-1:0]  clr_q, clr_d;
  logic              more_q, more_d, nmore;
  logic              rd_vld_q, rd_vld_d;
  logic              out_valid_q, out_valid_d;
  coord_t            qr_q, qr_d, qc_q, qc_d;
  coord_t            d_q, d_d, nd;
  coord_t            k_q, k_d, nk;
  logic              side_q, side_d, nside;
  coord_t            pr_q, pr_d, pc_q, pc_d;
  logic [HW-1:0]     cls_q, cls_d;
  logic              res_found_q, res_found_d;
  logic              res_bad_q, res_bad_d;
  logic [OW-1:0]     res_row_q, res_row_d, res_col_q, res_col_d;
  logic [HW-1:0]     res_class_q, res_class_d;
  logic              found_q, found_d, bad_q, bad_d;
  logic [OW-1:0]     hrow_q, hrow_d, hcol_q, hcol_d;
  logic [HW-1:0]     hcls_q, hcls_d;

  ring_t  gc;
  ring_t  gn;
  coord_t cur_pr;
  coord_t cur_pc;
  logic   go_col;
  logic   go_ring;
  logic   hit;
  logic   wr_ok;
  logic   start_off;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= gncrs_pkg::ST_CLEAR;
      clr_q       <= '0;
      more_q      <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      clr_q       <= clr_d;
      more_q      <= more_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q        <= ph_d;
    qr_q        <= qr_d;
    qc_q        <= qc_d;
    d_q         <= d_d;
    k_q         <= k_d;
    side_q      <= side_d;
    pr_q        <= pr_d;
    pc_q        <= pc_d;
    cls_q       <= cls_d;
    res_found_q <= res_found_d;
    res_bad_q   <= res_bad_d;
    res_row_q   <= res_row_d;
    res_col_q   <= res_col_d;
    res_class_q <= res_class_d;
    found_q     <= found_d;
    bad_q       <= bad_d;
    hrow_q      <= hrow_d;
    hcol_q      <= hcol_d;
    hcls_q      <= hcls_d;
  end

  // Ring walk: geometry of the current ring and of the next ring
  assign gc = ring_geo(qr_q, qc_q, d_q);
  assign gn = ring_geo(qr_q, qc_q, d_q + coord_t'(1));

  always_comb begin
    if (ph_q == gncrs_pkg::PH_ROW) begin
      cur_pr = side_q ? (qr_q + d_q) : (qr_q - d_q);
      cur_pc = k_q;
    end else begin
      cur_pr = k_q;
      cur_pc = side_q ? (qc_q + d_q) : (qc_q - d_q);
    end
  end

  always_comb begin
    nd      = d_q;
    nph     = ph_q;
    nside   = side_q;
    nk      = k_q;
    nmore   = 1'b1;
    go_col  = 1'b0;
    go_ring = 1'b0;
    if (d_q == '0) begin
      go_ring = 1'b1;
    end else if (ph_q == gncrs_pkg::PH_ROW) begin
      if (!side_q && gc.bot_ok) begin
        nside = 1'b1;
      end else if (k_q < gc.row_hi) begin
        nk    = k_q + coord_t'(1);
        nside = !gc.top_ok;
      end else begin
        go_col = 1'b1;
      end
    end else begin
      if (!side_q && gc.right_ok) begin
        nside = 1'b1;
      end else if (k_q < gc.col_hi) begin
        nk    = k_q + coord_t'(1);
        nside = !gc.left_ok;
      end else begin
        go_ring = 1'b1;
      end
    end
    if (go_col) begin
      if (gc.left_ok || gc.right_ok) begin
        nph   = gncrs_pkg::PH_COL;
        nk    = gc.col_lo;
        nside = !gc.left_ok;
      end else begin
        go_ring = 1'b1;
      end
    end
    if (go_ring) begin
      nd = d_q + coord_t'(1);
      if (!gn.any) begin
        nmore = 1'b0;
      end else if (gn.top_ok || gn.bot_ok) begin
        nph   = gncrs_pkg::PH_ROW;
        nk    = gn.row_lo;
        nside = !gn.top_ok;
      end else begin
        nph   = gncrs_pkg::PH_COL;
        nk    = gn.col_lo;
        nside = !gn.left_ok;
      end
    end
  end

  assign hit = rd_vld_q && mem_rdata_q[2] && (mem_rdata_q[1:0] == cls_q);
  assign wr_ok = (int'(row_i) < int'(GRID_SIDE)) && (int'(col_i) < int'(GRID_SIDE)) &&
                 (item_class_i <= gncrs_pkg::MaxClass);
  assign start_off = (int'(row_i) >= int'(GRID_SIDE)) || (int'(col_i) >= int'(GRID_SIDE));

  always_comb begin
    st_d        = st_q;
    clr_d       = clr_q;
    more_d      = more_q;
    rd_vld_d    = rd_vld_q;
    ph_d        = ph_q;
    qr_d        = qr_q;
    qc_d        = qc_q;
    d_d         = d_q;
    k_d         = k_q;
    side_d      = side_q;
    pr_d        = pr_q;
    pc_d        = pc_q;
    cls_d       = cls_q;
    res_found_d = res_found_q;
    res_bad_d   = res_bad_q;
    res_row_d   = res_row_q;
    res_col_d   = res_col_q;
    res_class_d = res_class_q;
    found_d     = found_q;
    bad_d       = bad_q;
    hrow_d      = hrow_q;
    hcol_d      = hcol_q;
    hcls_d      = hcls_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (st_q)
      gncrs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          st_d = gncrs_pkg::ST_IDLE;
        end
      end

      gncrs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (kind_i == gncrs_pkg::KindWrite) begin
            if (wr_ok) begin
              mem_we    = 1'b1;
              mem_waddr = cell_addr(coord_t'(row_i), coord_t'(col_i));
              mem_wdata = present_i ? {1'b1, item_class_i[HW-1:0]} : 3'b000;
            end
          end else begin
            cls_d       = item_class_i[HW-1:0];
            qr_d        = coord_t'(row_i);
            qc_d        = coord_t'(col_i);
            res_found_d = 1'b0;
            res_bad_d   = 1'b0;
            res_row_d   = '0;
            res_col_d   = '0;
            res_class_d = '0;
            if (item_class_i > gncrs_pkg::MaxClass) begin
              res_bad_d = 1'b1;
              st_d      = gncrs_pkg::ST_DONE;
            end else if (start_off) begin
              st_d = gncrs_pkg::ST_DONE;
            end else begin
              st_d     = gncrs_pkg::ST_SEARCH;
              d_d      = '0;
              ph_d     = gncrs_pkg::PH_ROW;
              side_d   = 1'b0;
              k_d      = coord_t'(col_i);
              more_d   = 1'b1;
              rd_vld_d = 1'b0;
            end
          end
        end
      end

      gncrs_pkg::ST_SEARCH: begin
        if (hit) begin
          res_found_d = 1'b1;
          res_row_d   = pr_q[OW-1:0];
          res_col_d   = pc_q[OW-1:0];
          res_class_d = cls_q;
          more_d      = 1'b0;
          rd_vld_d    = 1'b0;
          st_d        = gncrs_pkg::ST_DONE;
        end else if (more_q) begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(cur_pr, cur_pc);
          rd_vld_d  = 1'b1;
          pr_d      = cur_pr;
          pc_d      = cur_pc;
          d_d       = nd;
          ph_d      = nph;
          side_d    = nside;
          k_d       = nk;
          more_d    = nmore;
        end else begin
          rd_vld_d = 1'b0;
          st_d     = gncrs_pkg::ST_DONE;
        end
      end

      gncrs_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          bad_d       = res_bad_q;
          hrow_d      = res_row_q;
          hcol_d      = res_col_q;
          hcls_d      = res_class_q;
          st_d        = gncrs_pkg::ST_IDLE;
        end
      end

      default: begin
        st_d = gncrs_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (st_q != gncrs_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign bad_query_o = bad_q;
  assign hit_row_o   = hrow_q;
  assign hit_col_o   = hcol_q;
  assign hit_class_o = hcls_q;

endmodule

`default_nettype wire

[tb/ring_search_checker.sv]
module ring_search_checker
  import gncrs_pkg::*;
#(
  parameter int unsigned GRID_SIDE = GridSideDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                kind_i,
  input  logic [CoordInW-1:0] row_i,
  input  logic [CoordInW-1:0] col_i,
  input  logic [ClassW-1:0]   item_class_i,
  input  logic                present_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                found_i,
  input  logic                bad_query_i,
  input  logic [CoordInW-1:0] hit_row_i,
  input  logic [CoordInW-1:0] hit_col_i,
  input  logic [HitClassW-1:0] hit_class_i,
  output int                  errors_o,
  output int                  pending_o,
  output int                  hits_o,
  output int                  bad_queries_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Side = GRID_SIDE;
  localparam int ShowLimit = 200;

  typedef struct packed {
    logic                 found;
    logic                 bad_query;
    logic [CoordInW-1:0]  hit_row;
    logic [CoordInW-1:0]  hit_col;
    logic [HitClassW-1:0] hit_class;
  } answer_t;

  logic           occupied   [Side*Side];
  logic [1:0]     cell_class [Side*Side];
  answer_t        answers_due[$];
  int             shown = 0;

  function automatic bit holds_class(int r, int c, logic [1:0] cls);
    if (r < 0 || c < 0 || r >= Side || c >= Side) return 1'b0;
    return occupied[r*Side+c] && cell_class[r*Side+c] == cls;
  endfunction

  function automatic answer_t hit_at(int r, int c, logic [1:0] cls);
    answer_t a;
    a = '0;
    a.found = 1'b1;
    a.hit_row = r[CoordInW-1:0];
    a.hit_col = c[CoordInW-1:0];
    a.hit_class = cls;
    return a;
  endfunction

  // start cell first, then square rings outward; rows of a ring before its columns
  function automatic answer_t nearest_match(int r, int c, logic [ClassW-1:0] cls);
    answer_t    none;
    logic [1:0] want;
    none = '0;
    want = cls[1:0];
    if (cls > MaxClass) begin
      none.bad_query = 1'b1;
      return none;
    end
    if (r >= Side || c >= Side) return none;
    if (holds_class(r, c, want)) return hit_at(r, c, want);
    for (int d = 1; r - d >= 0 || r + d < Side || c - d >= 0 || c + d < Side; d++) begin
      for (int k = c - d; k <= c + d; k++) begin
        if (holds_class(r - d, k, want)) return hit_at(r - d, k, want);
        if (holds_class(r + d, k, want)) return hit_at(r + d, k, want);
      end
      for (int k = r - d; k < r + d; k++) begin
        if (holds_class(k, c - d, want)) return hit_at(k, c - d, want);
        if (holds_class(k, c + d, want)) return hit_at(k, c + d, want);
      end
    end
    return none;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      errors_o++;
      if (shown < ShowLimit) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end else if (shown == ShowLimit) begin
        $display("%0t: further mismatches not shown", $time);
      end
      shown++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t due;
    int      idx;
    if (!rst_ni) begin
      for (int i = 0; i < Side*Side; i++) begin
        occupied[i] = 1'b0;
        cell_class[i] = '0;
      end
      answers_due.delete();
      errors_o = 0;
      pending_o = 0;
      hits_o = 0;
      bad_queries_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (answers_due.size() == 0) begin
          errors_o++;
          $display("%0t: result transfer with no query waiting, expected none, got found=%0d "
                   , $time, found_i, "bad=%0d row=%0d col=%0d class=%0d",
                   bad_query_i, hit_row_i, hit_col_i, hit_class_i);
        end else begin
          due = answers_due.pop_front();
          compare_field("found", due.found, found_i);
          compare_field("bad_query", due.bad_query, bad_query_i);
          compare_field("hit_row", due.hit_row, hit_row_i);
          compare_field("hit_col", due.hit_col, hit_col_i);
          compare_field("hit_class", due.hit_class, hit_class_i);
          if (due.found) hits_o++;
          if (due.bad_query) bad_queries_o++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KindWrite) begin
          if (row_i < Side && col_i < Side && item_class_i <= MaxClass) begin
            idx = int'(row_i) * Side + int'(col_i);
            occupied[idx] = present_i;
            cell_class[idx] = present_i ? item_class_i[1:0] : 2'd0;
          end
        end else begin
          answers_due.push_back(nearest_match(row_i, col_i, item_class_i));
        end
      end
      pending_o = answers_due.size();
    end
  end

endmodule

[tb/tb_grid_nearest_class_ring_search.sv]
module tb_grid_nearest_class_ring_search;
  timeunit 1ns;
  timeprecision 1ps;

  import gncrs_pkg::*;

  localparam int Side = GridSideDef;
  localparam int RandomItems = 1800;
  localparam int CycleLimit = 2_000_000;
  localparam int DrainCycles = 300;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 kind = KindWrite;
  logic [CoordInW-1:0]  row = '0;
  logic [CoordInW-1:0]  col = '0;
  logic [ClassW-1:0]    item_class = '0;
  logic                 present = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 found;
  logic                 bad_query;
  logic [CoordInW-1:0]  hit_row;
  logic [CoordInW-1:0]  hit_col;
  logic [HitClassW-1:0] hit_class;

  int errors, pending, hits, bad_queries;
  int sender_idle_pct = 0;
  int stall_pct = 0;
  int fill_pct = 30;
  int writes_sent = 0;
  int queries_sent = 0;
  int cycle_count = 0;

  grid_nearest_class_ring_search #(.GRID_SIDE(Side)) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .row_i        (row),
    .col_i        (col),
    .item_class_i (item_class),
    .present_i    (present),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .found_o      (found),
    .bad_query_o  (bad_query),
    .hit_row_o    (hit_row),
    .hit_col_o    (hit_col),
    .hit_class_o  (hit_class)
  );

  ring_search_checker #(.GRID_SIDE(Side)) answer_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .kind_i        (kind),
    .row_i         (row),
    .col_i         (col),
    .item_class_i  (item_class),
    .present_i     (present),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .found_i       (found),
    .bad_query_i   (bad_query),
    .hit_row_i     (hit_row),
    .hit_col_i     (hit_col),
    .hit_class_i   (hit_class),
    .errors_o      (errors),
    .pending_o     (pending),
    .hits_o        (hits),
    .bad_queries_o (bad_queries)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("status: fail");
    $finish;
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input logic k, input int r, input int c, input int cls,
                           input logic p);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid = 1'b1;
    kind = k;
    row = r[CoordInW-1:0];
    col = c[CoordInW-1:0];
    item_class = cls[ClassW-1:0];
    present = p;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    if (k == KindWrite) writes_sent++;
    else queries_sent++;
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 99) < 20) return $urandom_range(0, 1) ? Side - 1 : 0;
    return $urandom_range(0, Side - 1);
  endfunction

  task automatic send_random();
    logic k;
    int   r, c, cls;
    logic p;
    k = ($urandom_range(0, 99) < 55) ? KindQuery : KindWrite;
    r = rand_coord();
    c = rand_coord();
    cls = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(4, 7);
    p = ($urandom_range(0, 99) < fill_pct);
    send_item(k, r, c, cls, p);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty grid: full sweep with no hit, then bad classes
    send_item(KindQuery, 0, 0, 0, 1'b0);
    send_item(KindQuery, 15, 15, 7, 1'b1);
    send_item(KindQuery, 8, 8, 4, 1'b0);
    // far corner must be reached from the opposite corner
    send_item(KindWrite, 15, 15, 3, 1'b1);
    send_item(KindQuery, 0, 0, 3, 1'b0);
    send_item(KindQuery, 15, 15, 3, 1'b0);
    send_item(KindQuery, 15, 15, 2, 1'b0);
    // write with bad class is dropped
    send_item(KindWrite, 3, 3, 6, 1'b1);
    send_item(KindQuery, 3, 3, 2, 1'b1);
    // emptying a cell clears it
    send_item(KindWrite, 15, 15, 2, 1'b0);
    send_item(KindQuery, 15, 15, 3, 1'b0);
    send_item(KindQuery, 0, 0, 2, 1'b0);
    // ring order between two equally near cells
    send_item(KindWrite, 7, 7, 0, 1'b1);
    send_item(KindWrite, 7, 9, 0, 1'b1);
    send_item(KindQuery, 7, 8, 0, 1'b0);
    send_item(KindWrite, 0, 15, 1, 1'b1);
    send_item(KindWrite, 15, 0, 1, 1'b1);
    send_item(KindQuery, 0, 0, 1, 1'b0);
    send_item(KindQuery, 15, 15, 1, 1'b0);
    send_item(KindQuery, 0, 15, 5, 1'b1);
    send_item(KindWrite, 7, 7, 0, 1'b0);
    send_item(KindQuery, 7, 8, 0, 1'b0);
    send_item(KindQuery, 7, 8, 7, 1'b0);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          stall_pct = 0;
          fill_pct = 10;
        end
        1: begin
          sender_idle_pct = 56;
          stall_pct = 0;
          fill_pct = 45;
        end
        2: begin
          sender_idle_pct = 0;
          stall_pct = 56;
          fill_pct = 75;
        end
        default: begin
          sender_idle_pct = 31;
          stall_pct = 31;
          fill_pct = 25;
        end
      endcase
      repeat (RandomItems / 4) send_random();
      // hold off until every result of the phase is back
      in_valid = 1'b0;
      while (pending != 0) @(negedge clk_i);
    end

    stall_pct = 0;
    repeat (DrainCycles) @(negedge clk_i);

    $display("Covered %0d cell writes and %0d queries over four traffic phases", writes_sent,
             queries_sent);
    $display("with %0d queries hitting a cell and %0d rejected for a bad class", hits,
             bad_queries);
    if (errors == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/gncrs_pkg.sv
rtl/grid_nearest_class_ring_search.sv
tb/ring_search_checker.sv
tb/tb_grid_nearest_class_ring_search.sv
